/* hdl/nnact_pkg.sv */
// shared constants, types and the saturation helper for the activation unit
// no dependencies; used by nnact_front, nnact_back and nn_activation_unit_core

package nnact_pkg;

  // data format and register widths
  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 12;
  localparam int SLOPE_W    = 13;
  localparam int SLOPE_FRAC = 12;
  localparam int FUNC_W     = 3;
  localparam int CFG_W      = (SLOPE_W > FUNC_W) ? SLOPE_W : FUNC_W;

  // multiplier operand and product widths
  localparam int OP_MAX = (DATA_WIDTH > FRAC_BITS)
                          ? ((DATA_WIDTH > SLOPE_W) ? DATA_WIDTH : SLOPE_W)
                          : ((FRAC_BITS > SLOPE_W) ? FRAC_BITS : SLOPE_W);
  localparam int OP_W   = OP_MAX + 2;
  localparam int PROD_W = 2 * OP_W;

  // activation function codes
  localparam logic [FUNC_W-1:0] FUNC_LINEAR  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_SIGMOID = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_TANH    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_RELU    = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_LEAKY   = 3'd4;

  // register indexes
  localparam logic CFG_FUNC  = 1'b0;
  localparam logic CFG_SLOPE = 1'b1;

  // register reset values
  localparam logic [FUNC_W-1:0]  FUNC_RESET  = FUNC_LINEAR;
  localparam logic [SLOPE_W-1:0] SLOPE_RESET = 13'd410;

  // saturation bounds in product width
  localparam logic signed [PROD_W-1:0] SAT_HI =
    $signed({{(PROD_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}});
  localparam logic signed [PROD_W-1:0] SAT_LO = ~SAT_HI;

  // what the back half does with the first product
  typedef enum logic [1:0] {
    MODE_PASS,
    MODE_SCALE,
    MODE_DSIG,
    MODE_DTANH
  } mode_e;

  // stage record between the front and back halves
  typedef struct packed {
    logic                         valid;
    mode_e                        mode;
    logic signed [DATA_WIDTH-1:0] pass_val;
    logic signed [PROD_W-1:0]     prod;
    logic signed [DATA_WIDTH-1:0] dy;
  } mul_stage_t;

  // clamp a wide signed value to the data range
  function automatic logic signed [DATA_WIDTH-1:0] sat_data(
    input logic signed [PROD_W-1:0] v
  );
    logic signed [DATA_WIDTH-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[DATA_WIDTH-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[DATA_WIDTH-1:0];
    end else begin
      r = v[DATA_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

/* hdl/nnact_front.sv */
// front half: input register, function decode, piecewise sigmoid/tanh and
// the first multiplier stage; depends on nnact_pkg

module nnact_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_xfer_i,
  input  logic                                  op_i,
  input  logic signed [nnact_pkg::DATA_WIDTH-1:0] x_value_i,
  input  logic signed [nnact_pkg::DATA_WIDTH-1:0] fwd_output_i,
  input  logic signed [nnact_pkg::DATA_WIDTH-1:0] grad_in_i,
  input  logic [nnact_pkg::FUNC_W-1:0]          func_i,
  input  logic [nnact_pkg::SLOPE_W-1:0]         slope_i,
  output nnact_pkg::mul_stage_t                 stage_o
);

  localparam int DW   = nnact_pkg::DATA_WIDTH;
  localparam int FB   = nnact_pkg::FRAC_BITS;
  localparam int OPW  = nnact_pkg::OP_W;
  localparam int PW   = nnact_pkg::PROD_W;
  localparam int SW   = ((DW > FB + 3) ? DW : FB + 3) + 2;

  // piecewise sigmoid breakpoints and offsets
  localparam logic signed [SW-1:0] ONE     = SW'(1) <<< FB;
  localparam logic signed [SW-1:0] T_SAT   = ONE * SW'(5);
  localparam logic signed [SW-1:0] T_MID   = (ONE * SW'(19)) >>> 3;
  localparam logic signed [SW-1:0] OFF_HI  = (ONE * SW'(27)) >>> 5;
  localparam logic signed [SW-1:0] OFF_MID = (ONE * SW'(5)) >>> 3;
  localparam logic signed [SW-1:0] OFF_LOW = ONE >>> 1;
  localparam logic signed [OPW-1:0] ONE_OP = OPW'(1) <<< FB;

  // input stage registers
  logic                          s0_valid_q;
  logic                          s0_op_q;
  logic signed [DW-1:0]          s0_x_q;
  logic signed [DW-1:0]          s0_y_q;
  logic signed [DW-1:0]          s0_dy_q;
  logic [nnact_pkg::FUNC_W-1:0]  s0_func_q;
  logic [nnact_pkg::SLOPE_W-1:0] s0_slope_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= in_xfer_i;
    end
  end

  // item and config snapshot travel together
  always_ff @(posedge clk_i) begin
    s0_op_q    <= op_i;
    s0_x_q     <= x_value_i;
    s0_y_q     <= fwd_output_i;
    s0_dy_q    <= grad_in_i;
    s0_func_q  <= func_i;
    s0_slope_q <= slope_i;
  end

  // sigmoid on x or 2x, tanh derived from it
  logic                 is_tanh;
  logic signed [SW-1:0] xs;
  logic signed [SW-1:0] mag;
  logic signed [SW-1:0] sig_pos;
  logic signed [SW-1:0] sig_val;
  logic signed [SW-1:0] act;
  logic signed [DW-1:0] curve_val;

  assign is_tanh = (s0_func_q == nnact_pkg::FUNC_TANH);

  always_comb begin
    xs = $signed({{(SW-DW){s0_x_q[DW-1]}}, s0_x_q});
    if (is_tanh) begin
      xs = xs <<< 1;
    end
    mag = xs[SW-1] ? -xs : xs;
    if (mag >= T_SAT) begin
      sig_pos = ONE;
    end else if (mag >= T_MID) begin
      sig_pos = (mag >>> 5) + OFF_HI;
    end else if (mag >= ONE) begin
      sig_pos = (mag >>> 3) + OFF_MID;
    end else begin
      sig_pos = (mag >>> 2) + OFF_LOW;
    end
    sig_val = xs[SW-1] ? (ONE - sig_pos) : sig_pos;
    act     = is_tanh ? ((sig_val <<< 1) - ONE) : sig_val;
    curve_val = nnact_pkg::sat_data($signed({{(PW-SW){act[SW-1]}}, act}));
  end

  // operand views
  logic                  x_pos;
  logic signed [OPW-1:0] x_ext;
  logic signed [OPW-1:0] y_ext;
  logic signed [OPW-1:0] dy_ext;
  logic signed [OPW-1:0] slope_ext;

  assign x_pos     = !s0_x_q[DW-1] && (s0_x_q != '0);
  assign x_ext     = $signed({{(OPW-DW){s0_x_q[DW-1]}}, s0_x_q});
  assign y_ext     = $signed({{(OPW-DW){s0_y_q[DW-1]}}, s0_y_q});
  assign dy_ext    = $signed({{(OPW-DW){s0_dy_q[DW-1]}}, s0_dy_q});
  assign slope_ext = $signed({{(OPW-nnact_pkg::SLOPE_W){1'b0}}, s0_slope_q});

  // decode function and direction into a mode and multiplier operands
  nnact_pkg::mode_e      mode_d;
  logic signed [DW-1:0]  pass_d;
  logic signed [OPW-1:0] op_a;
  logic signed [OPW-1:0] op_b;

  always_comb begin
    mode_d = nnact_pkg::MODE_PASS;
    op_a   = x_ext;
    op_b   = slope_ext;
    if (!s0_op_q) begin
      pass_d = s0_x_q;
      case (s0_func_q) inside
        nnact_pkg::FUNC_SIGMOID, nnact_pkg::FUNC_TANH: begin
          pass_d = curve_val;
        end
        nnact_pkg::FUNC_RELU: begin
          pass_d = x_pos ? s0_x_q : '0;
        end
        nnact_pkg::FUNC_LEAKY: begin
          if (!x_pos) begin
            mode_d = nnact_pkg::MODE_SCALE;
          end
        end
        default: begin
          pass_d = s0_x_q;
        end
      endcase
    end else begin
      pass_d = s0_dy_q;
      case (s0_func_q)
        nnact_pkg::FUNC_SIGMOID: begin
          mode_d = nnact_pkg::MODE_DSIG;
          op_a   = y_ext;
          op_b   = ONE_OP - y_ext;
        end
        nnact_pkg::FUNC_TANH: begin
          mode_d = nnact_pkg::MODE_DTANH;
          op_a   = y_ext;
          op_b   = y_ext;
        end
        nnact_pkg::FUNC_RELU: begin
          pass_d = x_pos ? s0_dy_q : '0;
        end
        nnact_pkg::FUNC_LEAKY: begin
          if (!x_pos) begin
            mode_d = nnact_pkg::MODE_SCALE;
            op_a   = dy_ext;
          end
        end
        default: begin
          pass_d = s0_dy_q;
        end
      endcase
    end
  end

  // first multiplier stage
  logic signed [PW-1:0] prod_d;
  assign prod_d = op_a * op_b;

  logic                 s1_valid_q;
  nnact_pkg::mode_e     s1_mode_q;
  logic signed [DW-1:0] s1_pass_q;
  logic signed [PW-1:0] s1_prod_q;
  logic signed [DW-1:0] s1_dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_mode_q <= mode_d;
    s1_pass_q <= pass_d;
    s1_prod_q <= prod_d;
    s1_dy_q   <= s0_dy_q;
  end

  always_comb begin
    stage_o.valid    = s1_valid_q;
    stage_o.mode     = s1_mode_q;
    stage_o.pass_val = s1_pass_q;
    stage_o.prod     = s1_prod_q;
    stage_o.dy       = s1_dy_q;
  end

endmodule

/* hdl/nnact_back.sv */
// back half: derivative rounding, gradient multiplier and final
// round/saturate output register; depends on nnact_pkg

module nnact_back (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  nnact_pkg::mul_stage_t                   stage_i,
  output logic signed [nnact_pkg::DATA_WIDTH-1:0] result_o,
  output logic                                    result_valid_o
);

  localparam int DW = nnact_pkg::DATA_WIDTH;
  localparam int FB = nnact_pkg::FRAC_BITS;
  localparam int PW = nnact_pkg::PROD_W;

  localparam logic signed [PW-1:0] HALF_F = PW'(1) <<< (FB - 1);
  localparam logic signed [PW-1:0] HALF_S = PW'(1) <<< (nnact_pkg::SLOPE_FRAC - 1);
  localparam logic signed [PW-1:0] ONE_P  = PW'(1) <<< FB;

  // round the first product, finish the derivative or the leaky result
  logic signed [PW-1:0] rnd_f;
  logic signed [PW-1:0] rnd_s;
  logic                 pass_d;
  logic signed [DW-1:0] val_d;

  assign rnd_f = (stage_i.prod + HALF_F) >>> FB;
  assign rnd_s = (stage_i.prod + HALF_S) >>> nnact_pkg::SLOPE_FRAC;

  always_comb begin
    pass_d = 1'b1;
    val_d  = stage_i.pass_val;
    case (stage_i.mode)
      nnact_pkg::MODE_PASS: begin
        pass_d = 1'b1;
        val_d  = stage_i.pass_val;
      end
      nnact_pkg::MODE_SCALE: begin
        pass_d = 1'b1;
        val_d  = nnact_pkg::sat_data(rnd_s);
      end
      nnact_pkg::MODE_DSIG: begin
        pass_d = 1'b0;
        val_d  = nnact_pkg::sat_data(rnd_f);
      end
      nnact_pkg::MODE_DTANH: begin
        pass_d = 1'b0;
        val_d  = nnact_pkg::sat_data(ONE_P - rnd_f);
      end
    endcase
  end

  logic                 s2_valid_q;
  logic                 s2_pass_q;
  logic signed [DW-1:0] s2_val_q;
  logic signed [DW-1:0] s2_dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_pass_q <= pass_d;
    s2_val_q  <= val_d;
    s2_dy_q   <= stage_i.dy;
  end

  // gradient multiplier stage
  logic signed [2*DW-1:0] prod2_d;
  assign prod2_d = s2_val_q * s2_dy_q;

  logic                   s3_valid_q;
  logic                   s3_pass_q;
  logic signed [DW-1:0]   s3_val_q;
  logic signed [2*DW-1:0] s3_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_pass_q <= s2_pass_q;
    s3_val_q  <= s2_val_q;
    s3_prod_q <= prod2_d;
  end

  // final round and saturate
  logic signed [PW-1:0] prod2_ext;
  logic signed [PW-1:0] rnd2;
  logic signed [DW-1:0] result_d;

  assign prod2_ext = $signed({{(PW-2*DW){s3_prod_q[2*DW-1]}}, s3_prod_q});
  assign rnd2      = (prod2_ext + HALF_F) >>> FB;
  assign result_d  = s3_pass_q ? s3_val_q : nnact_pkg::sat_data(rnd2);

  logic                 out_valid_q;
  logic signed [DW-1:0] result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign result_o       = result_q;
  assign result_valid_o = out_valid_q;

endmodule

/* hdl/nn_activation_unit_core.sv */
// an item taken at the input passes five register stages (input, first multiplier,
// derivative, gradient multiplier, output) before its result is strobed;
// throughput one item per cycle, busy stays low and the receiver cannot stall,
// so the pipeline never backs up
// reset: asynchronous active low; clears stage valid bits, func_q to linear
// and slope_q to 410; depends on nnact_pkg, nnact_front and nnact_back

module nn_activation_unit_core (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start,
  output logic                                    busy,
  input  logic                                    op_i,
  input  logic signed [nnact_pkg::DATA_WIDTH-1:0] x_value_i,
  input  logic signed [nnact_pkg::DATA_WIDTH-1:0] fwd_output_i,
  input  logic signed [nnact_pkg::DATA_WIDTH-1:0] grad_in_i,
  output logic signed [nnact_pkg::DATA_WIDTH-1:0] result_o,
  output logic                                    result_valid_o,
  input  logic                                    cfg_we_i,
  input  logic                                    cfg_idx_i,
  input  logic [nnact_pkg::CFG_W-1:0]             cfg_wdata_i
);

  // configuration registers
  logic [nnact_pkg::FUNC_W-1:0]  func_q;
  logic [nnact_pkg::SLOPE_W-1:0] slope_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      func_q  <= nnact_pkg::FUNC_RESET;
      slope_q <= nnact_pkg::SLOPE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        nnact_pkg::CFG_FUNC:  func_q  <= cfg_wdata_i[nnact_pkg::FUNC_W-1:0];
        nnact_pkg::CFG_SLOPE: slope_q <= cfg_wdata_i[nnact_pkg::SLOPE_W-1:0];
        default: ;
      endcase
    end
  end

  // input transfer
  logic in_xfer;
  assign busy    = 1'b0;
  assign in_xfer = start & ~busy;

  nnact_pkg::mul_stage_t mid_stage;

  nnact_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_xfer_i    (in_xfer),
    .op_i         (op_i),
    .x_value_i    (x_value_i),
    .fwd_output_i (fwd_output_i),
    .grad_in_i    (grad_in_i),
    .func_i       (func_q),
    .slope_i      (slope_q),
    .stage_o      (mid_stage)
  );

  nnact_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .stage_i        (mid_stage),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

  // every transfer yields a result strobe
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> ##5 result_valid_o)
    else $error("result strobe missing after input transfer");

  // no result without a matching transfer
  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(in_xfer, 5))
    else $error("result strobe without input transfer");

  // forward relu and sigmoid never go negative
  a_fwd_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && $past(in_xfer && !op_i &&
      (func_q == nnact_pkg::FUNC_RELU || func_q == nnact_pkg::FUNC_SIGMOID), 5))
    |-> !result_o[nnact_pkg::DATA_WIDTH-1])
    else $error("negative forward relu or sigmoid result");

  // backward relu blocks the gradient for non-positive x
  a_relu_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && $past(in_xfer && op_i && func_q == nnact_pkg::FUNC_RELU &&
      (x_value_i[nnact_pkg::DATA_WIDTH-1] || x_value_i == '0), 5))
    |-> (result_o == '0))
    else $error("backward relu passed gradient for non-positive x");

endmodule
